// ----- rtl/smur_pkg.sv -----
// shared types, widths and codes for the split matrix update receiver
// no dependencies

package smur_pkg;

  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 6;

  localparam int CMD_W   = 2;
  localparam int DEV_W   = 2;
  localparam int SEQ_W   = 16;
  localparam int TIME_W  = 32;
  localparam int KEYS_W  = 24;
  localparam int KIND_W  = 2;
  localparam int ROW_W   = 2;
  localparam int COL_W   = 4;
  localparam int TMO_W   = 16;
  localparam int STALE_W = 15;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CMD_W-1:0] CMD_UPDATE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK      = 2'd2;

  localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;

  localparam logic [DEV_W-1:0] DEV_LEFT  = 2'd0;
  localparam logic [DEV_W-1:0] DEV_RIGHT = 2'd1;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_STALE   = 1'b1;

  localparam logic [TMO_W-1:0]   TIMEOUT_RST = 16'd2000;
  localparam logic [STALE_W-1:0] STALE_RST   = 15'd100;

  typedef struct packed {
    logic [TMO_W-1:0]   timeout_ms;
    logic [STALE_W-1:0] stale_window;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DEV_W-1:0]  device;
    logic [SEQ_W-1:0]  sequence_req;
    logic              checksum_ok;
    logic [TIME_W-1:0] now_ms;
    logic [KEYS_W-1:0] key_rows;
    logic [KEYS_W-1:0] change_masks;
  } pkt_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEV_W-1:0]  out_device;
    logic [ROW_W-1:0]  key_row;
    logic [COL_W-1:0]  key_column;
    logic              pressed;
    logic [SEQ_W-1:0]  ack_sequence;
    logic              left_link;
    logic              right_link;
    logic              last;
  } res_item_t;

endpackage

// ----- rtl/smur_if.sv -----
// packet and result channel interfaces with valid/ready handshake
// depends on smur_pkg

interface smur_pkt_if import smur_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DEV_W-1:0]  device;
  logic [SEQ_W-1:0]  sequence_req;
  logic              checksum_ok;
  logic [TIME_W-1:0] now_ms;
  logic [KEYS_W-1:0] key_rows;
  logic [KEYS_W-1:0] change_masks;

  modport source (output valid, command, device, sequence_req, checksum_ok, now_ms,
                  key_rows, change_masks, input ready);
  modport sink (input valid, command, device, sequence_req, checksum_ok, now_ms,
                key_rows, change_masks, output ready);
endinterface

interface smur_res_if import smur_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DEV_W-1:0]  out_device;
  logic [ROW_W-1:0]  key_row;
  logic [COL_W-1:0]  key_column;
  logic              pressed;
  logic [SEQ_W-1:0]  ack_sequence;
  logic              left_link;
  logic              right_link;
  logic              last;

  modport source (output valid, kind, out_device, key_row, key_column, pressed,
                  ack_sequence, left_link, right_link, last, input ready);
  modport sink (input valid, kind, out_device, key_row, key_column, pressed,
                ack_sequence, left_link, right_link, last, output ready);
endinterface

// ----- rtl/split_matrix_update_receiver.sv -----
// split keyboard matrix update receiver: an update is scanned one key position per cycle
// in the row/column scan, holding on a changed key position while the result channel stalls;
// one item at a time. synchronous reset clears the key matrix, sequences, times and links,
// and loads timeout 2000 and window 100

module split_matrix_update_receiver import smur_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  smur_pkt_if.sink          pkt,
  smur_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  pkt_item_t pkt_item;
  logic      em_valid;
  logic      em_ready;
  res_item_t em_item;
  res_item_t res_item;

  assign pkt_item.command      = pkt.command;
  assign pkt_item.device       = pkt.device;
  assign pkt_item.sequence_req = pkt.sequence_req;
  assign pkt_item.checksum_ok  = pkt.checksum_ok;
  assign pkt_item.now_ms       = pkt.now_ms;
  assign pkt_item.key_rows     = pkt.key_rows;
  assign pkt_item.change_masks = pkt.change_masks;

  smur_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smur_core #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pkt_valid (pkt.valid),
    .pkt_ready (pkt.ready),
    .pkt_item  (pkt_item),
    .em_valid  (em_valid),
    .em_ready  (em_ready),
    .em_item   (em_item)
  );

  smur_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .em_valid  (em_valid),
    .em_ready  (em_ready),
    .em_item   (em_item),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_item  (res_item)
  );

  assign res.kind         = res_item.kind;
  assign res.out_device   = res_item.out_device;
  assign res.key_row      = res_item.key_row;
  assign res.key_column   = res_item.key_column;
  assign res.pressed      = res_item.pressed;
  assign res.ack_sequence = res_item.ack_sequence;
  assign res.left_link    = res_item.left_link;
  assign res.right_link   = res_item.right_link;
  assign res.last         = res_item.last;

endmodule

// ----- rtl/smur_cfg.sv -----
// apb-style register file: timeout and stale window
// depends on smur_pkg

module smur_cfg import smur_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_reg;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.timeout_ms   <= TIMEOUT_RST;
      cfg_reg.stale_window <= STALE_RST;
    end else if (wr) begin
      case (paddr[2])
        REG_TIMEOUT: cfg_reg.timeout_ms   <= pwdata[TMO_W-1:0];
        REG_STALE:   cfg_reg.stale_window <= pwdata[STALE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TIMEOUT: prdata = {{(APB_DW-TMO_W){1'b0}}, cfg_reg.timeout_ms};
      REG_STALE:   prdata = {{(APB_DW-STALE_W){1'b0}}, cfg_reg.stale_window};
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- rtl/smur_core.sv -----
// sequencer: sequence check, timeout check and row/column key scan
// holds key matrix and per-half link state; depends on smur_pkg

module smur_core import smur_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      pkt_valid,
  output logic      pkt_ready,
  input  pkt_item_t pkt_item,
  output logic      em_valid,
  input  logic      em_ready,
  output res_item_t em_item
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SEQ      = 3'd2;
  localparam logic [2:0] S_TCHECK   = 3'd3;
  localparam logic [2:0] S_ROW      = 3'd4;
  localparam logic [2:0] S_COL      = 3'd5;
  localparam logic [2:0] S_FLUSH    = 3'd6;
  localparam logic [2:0] S_ACK      = 3'd7;

  logic [2:0]        state;
  pkt_item_t         pkt;
  logic [KEYS_W-1:0] rows_sh;
  logic [KEYS_W-1:0] masks_sh;
  logic              tick;
  logic              h;
  logic [RW-1:0]     r;
  logic [CW-1:0]     c;
  logic [COLS-1:0]   sel;
  logic [COLS-1:0]   newr;
  logic              any;
  logic              flush_dev;

  logic [COLS-1:0]   matrix [2][ROWS];
  logic [SEQ_W-1:0]  acc_seq [2];
  logic [TIME_W-1:0] seen [2];
  logic [1:0]        conn;

  // shared arithmetic
  logic [SEQ_W-1:0]  seq_delta;
  logic signed [SEQ_W:0] sd;
  logic signed [SEQ_W:0] neg_win;
  logic              is_new;
  logic [TIME_W-1:0] elapsed;
  logic              timed_out;

  logic [COLS-1:0]   old_row;
  logic [COLS-1:0]   new_row;
  logic [COLS-1:0]   chg;
  logic              hit;
  logic              row_end;
  logic              scan_end;
  logic              offset;
  logic [COL_W-1:0]  col_off;

  assign seq_delta = pkt.sequence_req - acc_seq[h];
  assign sd        = signed'({seq_delta[SEQ_W-1], seq_delta});
  assign neg_win   = -signed'({2'b00, cfg.stale_window});
  assign is_new    = (sd > 0) || (sd < neg_win);
  assign elapsed   = pkt.now_ms - seen[h];
  assign timed_out = conn[h] && (elapsed > {{(TIME_W-TMO_W){1'b0}}, cfg.timeout_ms});

  always_comb begin
    old_row = matrix[h][r];
    new_row = rows_sh[COLS-1:0];
    chg     = masks_sh[COLS-1:0];
    if (chg == '0) begin
      chg = old_row ^ new_row;
    end
  end

  assign hit      = sel[c];
  assign row_end  = (c == CW'(COLS - 1));
  assign scan_end = (r == RW'(ROWS - 1));
  assign offset   = tick ? h : (pkt.device == DEV_RIGHT);
  assign col_off  = offset ? COL_W'(COLS) : '0;

  assign pkt_ready = (state == S_IDLE);

  always_comb begin
    em_valid = 1'b0;
    em_item  = '0;
    em_item.left_link  = conn[0];
    em_item.right_link = conn[1];
    case (state)
      S_COL: begin
        em_valid           = hit;
        em_item.kind       = KIND_KEY;
        em_item.out_device = tick ? {1'b0, h} : pkt.device;
        em_item.key_row    = ROW_W'(r);
        em_item.key_column = COL_W'(c) + col_off;
        em_item.pressed    = newr[c];
      end
      S_FLUSH: begin
        em_valid           = 1'b1;
        em_item.kind       = KIND_FLUSH;
        em_item.out_device = tick ? {1'b0, flush_dev} : pkt.device;
        em_item.last       = tick;
      end
      S_ACK: begin
        em_valid             = 1'b1;
        em_item.kind         = KIND_ACK;
        em_item.out_device   = pkt.device;
        em_item.ack_sequence = pkt.sequence_req;
        em_item.last         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      conn  <= '0;
      for (int i = 0; i < 2; i++) begin
        acc_seq[i] <= '0;
        seen[i]    <= '0;
        for (int j = 0; j < ROWS; j++) begin
          matrix[i][j] <= '0;
        end
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (pkt_valid) begin
            pkt   <= pkt_item;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          rows_sh  <= pkt.key_rows;
          masks_sh <= pkt.change_masks;
          any      <= 1'b0;
          r        <= '0;
          state    <= S_IDLE;
          if (pkt.command == CMD_TICK) begin
            tick  <= 1'b1;
            h     <= 1'b0;
            state <= S_TCHECK;
          end else if (pkt.command == CMD_HEARTBEAT) begin
            if (pkt.checksum_ok && pkt.device[1] == 1'b0) begin
              seen[pkt.device[0]] <= pkt.now_ms;
              conn[pkt.device[0]] <= 1'b1;
            end
          end else if (pkt.command == CMD_UPDATE && pkt.checksum_ok) begin
            tick  <= 1'b0;
            h     <= (pkt.device != DEV_LEFT);
            state <= S_SEQ;
          end
        end
        S_SEQ: begin
          state <= is_new ? S_ROW : S_ACK;
        end
        S_TCHECK: begin
          r <= '0;
          if (timed_out) begin
            conn[h]   <= 1'b0;
            any       <= 1'b1;
            flush_dev <= h;
            state     <= S_ROW;
          end else if (h == 1'b0) begin
            h <= 1'b1;
          end else begin
            state <= any ? S_FLUSH : S_IDLE;
          end
        end
        S_ROW: begin
          c <= '0;
          if (tick) begin
            sel  <= old_row;
            newr <= '0;
          end else begin
            sel  <= chg & (old_row ^ new_row);
            newr <= new_row;
          end
          state <= S_COL;
        end
        S_COL: begin
          if (!hit || em_ready) begin
            if (row_end) begin
              matrix[h][r] <= newr;
              rows_sh      <= rows_sh >> COLS;
              masks_sh     <= masks_sh >> COLS;
              if (scan_end) begin
                if (tick) begin
                  if (h == 1'b0) begin
                    h     <= 1'b1;
                    state <= S_TCHECK;
                  end else begin
                    state <= S_FLUSH;
                  end
                end else begin
                  seen[h]    <= pkt.now_ms;
                  conn[h]    <= 1'b1;
                  acc_seq[h] <= pkt.sequence_req;
                  state      <= S_FLUSH;
                end
              end else begin
                r     <= r + 1'b1;
                state <= S_ROW;
              end
            end else begin
              c <= c + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (em_ready) begin
            state <= tick ? S_IDLE : S_ACK;
          end
        end
        S_ACK: begin
          if (em_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/smur_outreg.sv -----
// result output register between the sequencer and the result channel
// depends on smur_pkg

module smur_outreg import smur_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      em_valid,
  output logic      em_ready,
  input  res_item_t em_item,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_item
);

  logic      valid;
  res_item_t item;

  assign em_ready  = !valid || res_ready;
  assign res_valid = valid;
  assign res_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (em_ready) begin
      valid <= em_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (em_ready && em_valid) begin
      item <= em_item;
    end
  end

endmodule

// ----- rtl/smur_chk.sv -----
// port-level checks on the receiver, bound to the top level
// depends on smur_pkg and split_matrix_update_receiver

module smur_chk import smur_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              pkt_valid,
  input logic              pkt_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [KIND_W-1:0] res_kind,
  input logic [ROW_W-1:0]  res_key_row,
  input logic [COL_W-1:0]  res_key_column,
  input logic              res_pressed,
  input logic [SEQ_W-1:0]  res_ack_sequence,
  input logic              res_last
);

  // one item in flight: ready drops after each accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_ready |=> !pkt_ready)
    else $error("packet channel ready right after an accepted item");

  a_non_key_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind != KIND_KEY |->
      res_key_row == '0 && res_key_column == '0 && !res_pressed)
    else $error("flush or acknowledge carries key fields");

  a_ack_seq_only: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind != KIND_ACK |-> res_ack_sequence == '0)
    else $error("sequence echoed outside an acknowledge");

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_ACK |-> res_last)
    else $error("acknowledge not marked last");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_last))
    else $error("stalled result changed");

endmodule

bind split_matrix_update_receiver smur_chk u_chk (
  .clk              (clk),
  .rst              (rst),
  .pkt_valid        (pkt.valid),
  .pkt_ready        (pkt.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_kind         (res.kind),
  .res_key_row      (res.key_row),
  .res_key_column   (res.key_column),
  .res_pressed      (res.pressed),
  .res_ack_sequence (res.ack_sequence),
  .res_last         (res.last)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for split_matrix_update_receiver: directed and random packets with a local predictor
// depends on smur_pkg, smur_pkt_if, smur_res_if and the receiver rtl

module tb_top;
  import smur_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [DEV_W-1:0] DEV_OTHER   = 2'd2;
  localparam logic [DEV_W-1:0] DEV_SPARE   = 2'd3;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 80;

  class matrix_event_scoreboard;
    res_item_t           expected_events[$];
    logic [COLS_DEF-1:0] held[2][ROWS_DEF];
    logic [SEQ_W-1:0]    acc_seq[2];
    logic [TIME_W-1:0]   seen_at[2];
    logic                linked[2];
    logic [TMO_W-1:0]    timeout_ms;
    logic [STALE_W-1:0]  stale_window;
    int                  errors;

    function new();
      for (int h = 0; h < 2; h++) begin
        for (int r = 0; r < ROWS_DEF; r++) held[h][r] = '0;
        acc_seq[h] = '0;
        seen_at[h] = '0;
        linked[h]  = 1'b0;
      end
      timeout_ms   = TIMEOUT_RST;
      stale_window = STALE_RST;
      errors       = 0;
    endfunction

    function void set_config(logic idx, logic [APB_DW-1:0] value);
      if (idx == REG_TIMEOUT) timeout_ms = value[TMO_W-1:0];
      else stale_window = value[STALE_W-1:0];
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void push_event(logic [KIND_W-1:0] kind, logic [DEV_W-1:0] dev, int row, int col,
                             logic pressed, logic [SEQ_W-1:0] seq);
      res_item_t e;
      e.kind         = kind;
      e.out_device   = dev;
      e.key_row      = ROW_W'(row);
      e.key_column   = COL_W'(col);
      e.pressed      = pressed;
      e.ack_sequence = seq;
      e.left_link    = linked[0];
      e.right_link   = linked[1];
      e.last         = 1'b0;
      expected_events.push_back(e);
    endfunction

    // works out the events one accepted packet causes and updates the local copy of state
    function void note_packet(pkt_item_t p);
      int                  h, n0, sd, win;
      bit                  any;
      logic [DEV_W-1:0]    flush_dev;
      logic [TIME_W-1:0]   silent;
      logic [SEQ_W-1:0]    diff;
      logic [COLS_DEF-1:0] old_row, new_row, sel;
      res_item_t           tail;
      n0 = expected_events.size();
      if (p.command == CMD_TICK) begin
        any = 0;
        flush_dev = DEV_LEFT;
        for (h = 0; h < 2; h++) begin
          silent = p.now_ms - seen_at[h];
          if (linked[h] && silent > TIME_W'(timeout_ms)) begin
            linked[h] = 1'b0;
            any = 1;
            flush_dev = DEV_W'(h);
            for (int r = 0; r < ROWS_DEF; r++) begin
              for (int c = 0; c < COLS_DEF; c++)
                if (held[h][r][c])
                  push_event(KIND_KEY, DEV_W'(h), r, c + (h != 0 ? COLS_DEF : 0), 1'b0, '0);
              held[h][r] = '0;
            end
          end
        end
        if (any) push_event(KIND_FLUSH, flush_dev, 0, 0, 1'b0, '0);
      end else if (p.command == CMD_HEARTBEAT) begin
        if (p.checksum_ok && (p.device == DEV_LEFT || p.device == DEV_RIGHT)) begin
          h = (p.device == DEV_LEFT) ? 0 : 1;
          seen_at[h] = p.now_ms;
          linked[h]  = 1'b1;
        end
      end else if (p.command == CMD_UPDATE && p.checksum_ok) begin
        h = (p.device == DEV_LEFT) ? 0 : 1;
        diff = p.sequence_req - acc_seq[h];
        sd = int'($signed(diff));
        win = int'(stale_window);
        if (sd > 0 || sd < -win) begin
          for (int r = 0; r < ROWS_DEF; r++) begin
            old_row = held[h][r];
            new_row = p.key_rows[r*COLS_DEF +: COLS_DEF];
            sel     = p.change_masks[r*COLS_DEF +: COLS_DEF];
            if (sel == '0) sel = old_row ^ new_row;
            for (int c = 0; c < COLS_DEF; c++)
              if (sel[c] && new_row[c] != old_row[c])
                push_event(KIND_KEY, p.device, r, c + (p.device == DEV_RIGHT ? COLS_DEF : 0),
                           new_row[c], '0);
            held[h][r] = new_row;
          end
          seen_at[h] = p.now_ms;
          linked[h]  = 1'b1;
          push_event(KIND_FLUSH, p.device, 0, 0, 1'b0, '0);
          acc_seq[h] = p.sequence_req;
        end
        push_event(KIND_ACK, p.device, 0, 0, 1'b0, p.sequence_req);
      end
      if (expected_events.size() > n0) begin
        tail = expected_events.pop_back();
        tail.last = 1'b1;
        expected_events.push_back(tail);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_event(res_item_t got);
      res_item_t want;
      if (expected_events.size() == 0) begin
        $error("result with nothing expected: kind %0d device %0d", got.kind, got.out_device);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("out_device", want.out_device, got.out_device);
      compare_field("key_row", want.key_row, got.key_row);
      compare_field("key_column", want.key_column, got.key_column);
      compare_field("pressed", want.pressed, got.pressed);
      compare_field("ack_sequence", want.ack_sequence, got.ack_sequence);
      compare_field("left_link", want.left_link, got.left_link);
      compare_field("right_link", want.right_link, got.right_link);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                cycles = 0;
  bit                tx_gapless, rx_gapless;
  logic [TIME_W-1:0] now_ms;
  logic [KEYS_W-1:0] key_state[2];

  matrix_event_scoreboard sb = new();

  smur_pkt_if pkt_ch ();
  smur_res_if res_ch ();

  split_matrix_update_receiver dut (
    .clk     (clk),
    .rst     (rst),
    .pkt     (pkt_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic pkt_item_t make_pkt(logic [CMD_W-1:0] cmd, logic [DEV_W-1:0] dev,
                                         logic [SEQ_W-1:0] seq, logic ok,
                                         logic [TIME_W-1:0] t, logic [KEYS_W-1:0] rows,
                                         logic [KEYS_W-1:0] masks);
    pkt_item_t p;
    p.command      = cmd;
    p.device       = dev;
    p.sequence_req = seq;
    p.checksum_ok  = ok;
    p.now_ms       = t;
    p.key_rows     = rows;
    p.change_masks = masks;
    return p;
  endfunction

  task automatic send_packet(input pkt_item_t p);
    int gap;
    gap = tx_gapless ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk);
      pkt_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pkt_ch.valid        <= 1'b1;
    pkt_ch.command      <= p.command;
    pkt_ch.device       <= p.device;
    pkt_ch.sequence_req <= p.sequence_req;
    pkt_ch.checksum_ok  <= p.checksum_ok;
    pkt_ch.now_ms       <= p.now_ms;
    pkt_ch.key_rows     <= p.key_rows;
    pkt_ch.change_masks <= p.change_masks;
    do @(posedge clk); while (pkt_ch.ready !== 1'b1);
    sb.note_packet(p);
  endtask

  // drop valid, wait for every expected event, then let the block finish silent work
  task automatic settle();
    @(negedge clk);
    pkt_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_config(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [TMO_W-1:0] tmo, input logic [STALE_W-1:0] win,
                           input int count);
    pkt_item_t         p;
    int                h, roll;
    logic [KEYS_W-1:0] flips;
    logic [SEQ_W-1:0]  base;
    settle();
    write_reg(REG_TIMEOUT, APB_DW'(tmo));
    write_reg(REG_STALE, APB_DW'(win));
    tx_gapless = ($urandom_range(0, 3) == 0);
    rx_gapless = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) now_ms += $urandom_range(0, 2 * int'(tmo) + 2);
      else now_ms += $urandom_range(0, 3);
      if ($urandom_range(0, 49) == 0) now_ms = $urandom;
      roll = $urandom_range(0, 99);
      p.command = (roll < 60) ? CMD_UPDATE : (roll < 75) ? CMD_HEARTBEAT :
                  (roll < 93) ? CMD_TICK : CMD_UNKNOWN;
      p.device = ($urandom_range(0, 9) == 0) ? DEV_W'($urandom_range(2, 3))
                                              : DEV_W'($urandom_range(0, 1));
      p.checksum_ok = ($urandom_range(0, 19) != 0);
      p.now_ms = now_ms;
      h = (p.device == DEV_LEFT) ? 0 : 1;
      base = sb.acc_seq[h];
      case ($urandom_range(0, 9))
        0: p.sequence_req = base;
        1: p.sequence_req = base - SEQ_W'($urandom_range(0, int'(win) + 1));
        2: p.sequence_req = SEQ_W'($urandom);
        default: p.sequence_req = base + SEQ_W'($urandom_range(1, 3));
      endcase
      flips = (KEYS_W'(1) << $urandom_range(0, KEYS_W - 1)) |
              (KEYS_W'(1) << $urandom_range(0, KEYS_W - 1));
      if ($urandom_range(0, 15) == 0) key_state[h] = KEYS_W'($urandom);
      else key_state[h] ^= flips;
      p.key_rows = key_state[h];
      roll = $urandom_range(0, 9);
      p.change_masks = (roll < 7) ? '0 : (roll < 9) ? KEYS_W'($urandom) : flips;
      if ($urandom_range(0, 24) == 0) tx_gapless = !tx_gapless;
      send_packet(p);
    end
  endtask

  // result side: random stalls, each accepted item checked in order
  initial begin
    res_item_t got;
    int        gap;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = rx_gapless ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.kind         = res_ch.kind;
      got.out_device   = res_ch.out_device;
      got.key_row      = res_ch.key_row;
      got.key_column   = res_ch.key_column;
      got.pressed      = res_ch.pressed;
      got.ack_sequence = res_ch.ack_sequence;
      got.left_link    = res_ch.left_link;
      got.right_link   = res_ch.right_link;
      got.last         = res_ch.last;
      sb.check_event(got);
      if ($urandom_range(0, 29) == 0) rx_gapless = !rx_gapless;
    end
  end

  initial begin
    logic [TIME_W-1:0] t0;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pkt_ch.valid        = 1'b0;
    pkt_ch.command      = CMD_UPDATE;
    pkt_ch.device       = DEV_LEFT;
    pkt_ch.sequence_req = '0;
    pkt_ch.checksum_ok  = 1'b0;
    pkt_ch.now_ms       = '0;
    pkt_ch.key_rows     = '0;
    pkt_ch.change_masks = '0;
    key_state[0]        = '0;
    key_state[1]        = '0;
    tx_gapless          = 1'b0;
    rx_gapless          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_TIMEOUT, APB_DW'(TIMEOUT_RST));
    write_reg(REG_STALE, APB_DW'(STALE_RST));

    // directed: full matrices, duplicates, stale window edges, other device, timeouts across wrap
    t0 = 32'hFFFF_FC00;
    send_packet(make_pkt(CMD_UPDATE, DEV_LEFT, 16'd1, 1'b1, t0, '1, '0));
    send_packet(make_pkt(CMD_UPDATE, DEV_LEFT, 16'd1, 1'b1, t0, '0, '0));
    send_packet(make_pkt(CMD_UPDATE, DEV_LEFT, 16'd2, 1'b0, t0, '0, '0));
    send_packet(make_pkt(CMD_UPDATE, DEV_RIGHT, 16'd1, 1'b1, t0, '1, '1));
    send_packet(make_pkt(CMD_UPDATE, DEV_OTHER, 16'd2, 1'b1, t0, 24'h00003F, '0));
    send_packet(make_pkt(CMD_UPDATE, DEV_SPARE, 16'd3, 1'b1, t0, '1, 24'h000001));
    send_packet(make_pkt(CMD_HEARTBEAT, DEV_OTHER, 16'd0, 1'b1, t0 + 5, '0, '0));
    send_packet(make_pkt(CMD_HEARTBEAT, DEV_LEFT, 16'd0, 1'b0, t0 + 5000, '0, '0));
    send_packet(make_pkt(CMD_UNKNOWN, DEV_LEFT, 16'd9, 1'b1, t0, '1, '1));
    send_packet(make_pkt(CMD_UPDATE, DEV_LEFT, 16'hFFFF, 1'b1, t0, '0, '0));
    send_packet(make_pkt(CMD_UPDATE, DEV_LEFT, 16'hFF9D, 1'b1, t0, '0, '0));
    send_packet(make_pkt(CMD_UPDATE, DEV_LEFT, 16'hFF9C, 1'b1, t0, '0, '0));
    send_packet(make_pkt(CMD_UPDATE, DEV_LEFT, 16'h7F9C, 1'b1, t0, 24'hAAAAAA, 24'h555555));
    send_packet(make_pkt(CMD_UPDATE, DEV_LEFT, 16'h7F9D, 1'b1, t0, '1, '1));
    send_packet(make_pkt(CMD_UPDATE, DEV_RIGHT, 16'd4, 1'b1, t0, '1, '0));
    send_packet(make_pkt(CMD_HEARTBEAT, DEV_LEFT, 16'd0, 1'b1, t0, '0, '0));
    send_packet(make_pkt(CMD_TICK, DEV_LEFT, 16'd0, 1'b1, t0 + 2000, '0, '0));
    send_packet(make_pkt(CMD_TICK, DEV_LEFT, 16'd0, 1'b1, t0 + 2001, '0, '0));
    send_packet(make_pkt(CMD_TICK, DEV_RIGHT, 16'd0, 1'b1, t0 + 2002, '0, '0));
    send_packet(make_pkt(CMD_HEARTBEAT, DEV_RIGHT, 16'd0, 1'b1, t0 + 3000, '0, '0));
    send_packet(make_pkt(CMD_TICK, DEV_LEFT, 16'd0, 1'b0, t0 + 5001, '0, '0));
    send_packet(make_pkt(CMD_UPDATE, DEV_LEFT, 16'h7F9E, 1'b1, 32'h0, '0, '0));

    now_ms = 32'd100;
    run_phase(TIMEOUT_RST, STALE_RST, 70);
    run_phase(16'd1, 15'd1, 70);
    run_phase(16'hFFFF, 15'h7FFF, 70);
    run_phase(TMO_W'($urandom_range(1, 4000)), STALE_W'($urandom_range(1, 32767)), 70);
    run_phase(16'd300, 15'd16383, 70);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
